// ----- rtl/core/cfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the complementary angle filter
// Fixed-point formats, register indexes, reset values, controller commands
// and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package cfa_pkg;

   // number formats
   localparam int AXES   = 3;            // axes per transfer
   localparam int F      = 16;           // fraction bits
   localparam int AW     = 32;           // angle, rate and result width
   localparam int CW     = 17;           // coefficient width (A, B)
   localparam int DTW    = 16;           // sample period width
   localparam int TAUW   = 24;           // time constant width
   localparam int HALF   = 1 << (F - 1); // rounding offset

   // configuration port
   localparam int NREG   = 5;
   localparam int IDXW   = 3;
   localparam int CSRW   = 24;

   localparam logic [IDXW-1:0] REG_ORDER = IDXW'(0);
   localparam logic [IDXW-1:0] REG_COEF_A = IDXW'(1);
   localparam logic [IDXW-1:0] REG_COEF_B = IDXW'(2);
   localparam logic [IDXW-1:0] REG_PERIOD = IDXW'(3);
   localparam logic [IDXW-1:0] REG_TAU = IDXW'(4);

   localparam logic [CW-1:0]   RST_COEF_A = CW'(64225);
   localparam logic [CW-1:0]   RST_COEF_B = CW'(1311);
   localparam logic [DTW-1:0]  RST_PERIOD = DTW'(655);
   localparam logic [TAUW-1:0] RST_TAU = TAUW'(32768);

   // unity in Q1.F
   localparam logic [CW-1:0] ONE = CW'(1) << F;

   // derived datapath widths
   localparam int KW   = TAUW + 1;       // A^2 * tau, rounded
   localparam int KSW  = KW + 1;         // same, as signed operand
   localparam int DFW  = AW + 1;         // rate difference
   localparam int KPW  = KSW + DFW;      // tau term product
   localparam int TW   = KPW + 1;        // one product term
   localparam int SW   = TW + 2;         // full sum
   localparam int RW   = SW - F;         // sum after dropping fraction bits

   localparam logic signed [AW-1:0] MAX_WORD = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] MIN_WORD = {1'b1, {(AW-1){1'b0}}};

   // configuration register file contents
   typedef struct packed {
      logic            order;
      logic [CW-1:0]   coef_a;
      logic [CW-1:0]   coef_b;
      logic [DTW-1:0]  period;
      logic [TAUW-1:0] tau;
   } cfg_type;

   // controller to datapath commands, one per step
   typedef struct packed {
      logic load;    // capture the input transfer
      logic coef;    // A^2, A*B, rate*dt
      logic term;    // products of history and coefficients
      logic part;    // partial sums, tau term
      logic commit;  // final sum, round, saturate, update history
   } cmd_type;

   // clamp a rounded sum to the signed result range
   function automatic logic signed [AW-1:0] sat_word(input logic signed [RW-1:0] x);
      logic [RW-AW:0] upper;
      upper = x[RW-1:AW-1];
      if (upper == '0 || upper == '1) begin
         return x[AW-1:0];
      end else if (x[RW-1]) begin
         return MIN_WORD;
      end else begin
         return MAX_WORD;
      end
   endfunction

endpackage

// ----- rtl/core/cfa_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_regs: configuration registers
// Write-only register file; writes to unknown indexes are dropped and data is
// masked to each register's width.
// ----------------------------------------------------------------------------
module cfa_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [cfa_pkg::IDXW-1:0]  csr_index,
   input  logic [cfa_pkg::CSRW-1:0]  csr_wdata,
   output cfa_pkg::cfg_type          cfg
);
   import cfa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode one write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ORDER:  cfg_in.order  = csr_wdata[0];
            REG_COEF_A: cfg_in.coef_a = csr_wdata[CW-1:0];
            REG_COEF_B: cfg_in.coef_b = csr_wdata[CW-1:0];
            REG_PERIOD: cfg_in.period = csr_wdata[DTW-1:0];
            REG_TAU:    cfg_in.tau    = csr_wdata[TAUW-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.order  <= 1'b0;
         cfg_ff.coef_a <= RST_COEF_A;
         cfg_ff.coef_b <= RST_COEF_B;
         cfg_ff.period <= RST_PERIOD;
         cfg_ff.tau    <= RST_TAU;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/cfa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_ctrl: step sequencer
// Walks each transfer through coefficient, product, partial-sum and commit
// steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module cfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfa_pkg::cmd_type  cmd
);
   import cfa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COEF = 3'd1;
   localparam logic [2:0] ST_TERM = 3'd2;
   localparam logic [2:0] ST_PART = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       valid_ff;
   logic       valid_in;
   logic       out_free;

   // result register can take a new value
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.term = 1'b1;
            state_in = ST_PART;
         end
         ST_PART: begin
            cmd.part = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on commit, cleared by a transfer
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- rtl/core/cfa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_dp: filter datapath
// Per-axis multipliers, partial sums, rounding and saturation, the history of
// both filter orders and the result register.
// ----------------------------------------------------------------------------
module cfa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cfa_pkg::cfg_type               cfg,
   input  cfa_pkg::cmd_type               cmd,
   input  logic signed [cfa_pkg::AW-1:0]  angle_in [cfa_pkg::AXES],
   input  logic signed [cfa_pkg::AW-1:0]  rate_in [cfa_pkg::AXES],
   output logic signed [cfa_pkg::AW-1:0]  fused_out [cfa_pkg::AXES]
);
   import cfa_pkg::*;

   localparam int AAW = 2 * CW;          // A*A, A*B
   localparam int KRW = CW + TAUW;       // A^2 * tau
   localparam int RDW = AW + DTW + 1;    // rate * dt
   localparam int DRW = AW + 1;          // rate * dt, rounded
   localparam int TTW = AW + 2;          // prev + rate*dt
   localparam int PAW = CW + 1 + TTW;    // A * t
   localparam int PBW = CW + 1 + AW;     // 17-bit coefficient times a word
   localparam int P1W = CW + 2 + AW;     // doubled coefficient times a word

   // coefficients
   logic [CW-1:0]  a_c;
   logic [CW-1:0]  b_c;
   logic [AAW-1:0] aa;
   logic [AAW-1:0] ab;
   logic [AAW:0]   aa_r;
   logic [AAW:0]   ab_r;
   logic [KRW-1:0] kk;
   logic [KRW:0]   kk_r;
   logic [CW-1:0]  a2_ff;
   logic [CW-1:0]  ab_ff;
   logic [KW-1:0]  k_ff;

   // captured transfer
   logic signed [AW-1:0]  ang_ff   [AXES];
   logic signed [AW-1:0]  rate_ff  [AXES];

   // history
   logic signed [AW-1:0]  fo_prev_ff  [AXES];
   logic signed [AW-1:0]  so_prev1_ff [AXES];
   logic signed [AW-1:0]  so_prev2_ff [AXES];
   logic signed [AW-1:0]  ang_hist_ff [AXES];
   logic signed [AW-1:0]  rate_hist_ff[AXES];

   // step registers
   logic signed [DRW-1:0] drt_ff [AXES];
   logic signed [DRW-1:0] drt_in [AXES];
   logic signed [TW-1:0]  t0_ff  [AXES];
   logic signed [TW-1:0]  t1_ff  [AXES];
   logic signed [TW-1:0]  t2_ff  [AXES];
   logic signed [TW-1:0]  t3_ff  [AXES];
   logic signed [TW-1:0]  t0_in  [AXES];
   logic signed [TW-1:0]  t1_in  [AXES];
   logic signed [TW-1:0]  t2_in  [AXES];
   logic signed [TW-1:0]  t3_in  [AXES];
   logic signed [TW:0]    sa_ff  [AXES];
   logic signed [TW:0]    sb_ff  [AXES];
   logic signed [TW:0]    sa_in  [AXES];
   logic signed [TW:0]    sb_in  [AXES];
   logic signed [KPW-1:0] kp_ff  [AXES];
   logic signed [KPW-1:0] kp_in  [AXES];
   logic signed [AW-1:0]  res_in [AXES];
   logic signed [AW-1:0]  fused_ff [AXES];

   // coefficient clamp and shared coefficient products
   always_comb begin
      a_c  = (cfg.coef_a > ONE) ? ONE : cfg.coef_a;
      b_c  = (cfg.coef_b > ONE) ? ONE : cfg.coef_b;
      aa   = AAW'(a_c) * AAW'(a_c);
      ab   = AAW'(a_c) * AAW'(b_c);
      aa_r = (AAW + 1)'(aa) + (AAW + 1)'(HALF);
      ab_r = (AAW + 1)'(ab) + (AAW + 1)'(HALF);
      kk   = KRW'(a2_ff) * KRW'(cfg.tau);
      kk_r = (KRW + 1)'(kk) + (KRW + 1)'(HALF);
   end

   // per-axis arithmetic of each step
   always_comb begin
      logic signed [RDW-1:0] rd;
      logic signed [RDW-1:0] rd_r;
      logic signed [TTW-1:0] tt;
      logic signed [PAW-1:0] pa;
      logic signed [PBW-1:0] pb;
      logic signed [P1W-1:0] p1;
      logic signed [PBW-1:0] p2;
      logic signed [PBW-1:0] p3;
      logic signed [P1W-1:0] p4;
      logic signed [DFW-1:0] diff;
      logic signed [KPW-1:0] kp;
      logic signed [SW-1:0]  sum;
      for (int i = 0; i < AXES; i++) begin
         // rate * dt, rounded
         rd        = rate_ff[i] * $signed({1'b0, cfg.period});
         rd_r      = rd + RDW'(HALF);
         drt_in[i] = rd_r[F +: DRW];

         // first-order products
         tt = TTW'(fo_prev_ff[i]) + TTW'(drt_ff[i]);
         pa = $signed({1'b0, a_c}) * tt;
         pb = $signed({1'b0, b_c}) * ang_ff[i];

         // second-order products
         p1 = $signed({1'b0, a_c, 1'b0}) * so_prev1_ff[i];
         p2 = $signed({1'b0, a2_ff}) * so_prev2_ff[i];
         p3 = $signed({1'b0, ONE - a2_ff}) * ang_ff[i];
         p4 = $signed({1'b0, ab_ff, 1'b0}) * ang_hist_ff[i];

         if (cfg.order) begin
            t0_in[i] = TW'(p1);
            t1_in[i] = -TW'(p2);
            t2_in[i] = TW'(p3);
            t3_in[i] = -TW'(p4);
         end else begin
            t0_in[i] = TW'(pa);
            t1_in[i] = TW'(pb);
            t2_in[i] = '0;
            t3_in[i] = '0;
         end

         // partial sums and tau term
         sa_in[i] = (TW + 1)'(t0_ff[i]) + (TW + 1)'(t1_ff[i]);
         sb_in[i] = (TW + 1)'(t2_ff[i]) + (TW + 1)'(t3_ff[i]);
         diff     = DFW'(rate_ff[i]) - DFW'(rate_hist_ff[i]);
         kp       = $signed({1'b0, k_ff}) * diff;
         kp_in[i] = cfg.order ? kp : '0;

         // final sum, round half up, saturate
         sum       = SW'(sa_ff[i]) + SW'(sb_ff[i]) + SW'(kp_ff[i]) + SW'(HALF);
         res_in[i] = sat_word(sum[F +: RW]);
      end
   end

   // step registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.coef) begin
         a2_ff <= aa_r[F +: CW];
         ab_ff <= ab_r[F +: CW];
      end
      if (cmd.term) begin
         k_ff <= kk_r[F +: KW];
      end
      for (int i = 0; i < AXES; i++) begin
         if (cmd.load) begin
            ang_ff[i]  <= angle_in[i];
            rate_ff[i] <= rate_in[i];
         end
         if (cmd.coef) begin
            drt_ff[i] <= drt_in[i];
         end
         if (cmd.term) begin
            t0_ff[i] <= t0_in[i];
            t1_ff[i] <= t1_in[i];
            t2_ff[i] <= t2_in[i];
            t3_ff[i] <= t3_in[i];
         end
         if (cmd.part) begin
            sa_ff[i] <= sa_in[i];
            sb_ff[i] <= sb_in[i];
            kp_ff[i] <= kp_in[i];
         end
         if (cmd.commit) begin
            fused_ff[i] <= res_in[i];
         end
      end
   end

   // filter history: only the selected order moves
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            fo_prev_ff[i]   <= '0;
            so_prev1_ff[i]  <= '0;
            so_prev2_ff[i]  <= '0;
            ang_hist_ff[i]  <= '0;
            rate_hist_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < AXES; i++) begin
            if (cfg.order) begin
               so_prev2_ff[i]  <= so_prev1_ff[i];
               so_prev1_ff[i]  <= res_in[i];
               ang_hist_ff[i]  <= ang_ff[i];
               rate_hist_ff[i] <= rate_ff[i];
            end else begin
               fo_prev_ff[i] <= res_in[i];
            end
         end
      end
   end

   assign fused_out = fused_ff;

endmodule

// ----- rtl/core/complementary_angle_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_angle_filter_top: three-axis complementary angle filter
// Fuses accelerometer angles with gyro rates, first or second order.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries three angles and three rates (signed Q16.16) per transfer;
//    rsp_* returns three fused angles (signed Q16.16, saturated).
//  - csr_write/csr_index/csr_wdata write the order, A, B, dt and tau; write
//    only while the filter is idle. Unknown indexes are ignored.
//  - A transfer is accepted only with the sequencer idle, then runs through
//    four steps (coefficients, products, partial sums, commit); the next
//    transfer is taken only once the commit step has returned the sequencer
//    to idle. The chained coefficient multiplies (A^2, then A^2*tau) and the
//    per-axis product/sum stages set this step sequence.
//  - The result sits in an output register; the next transfer is taken and
//    processed while it waits. If the receiver stalls, the commit step holds
//    until the output register is free, so nothing is lost.
//  - Reset (synchronous) restores the register defaults and clears the
//    history of both filter orders to zero.
// ----------------------------------------------------------------------------
module complementary_angle_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cfa_pkg::AW-1:0]       req_angle_x,
   input  logic signed [cfa_pkg::AW-1:0]       req_angle_y,
   input  logic signed [cfa_pkg::AW-1:0]       req_angle_z,
   input  logic signed [cfa_pkg::AW-1:0]       req_rate_x,
   input  logic signed [cfa_pkg::AW-1:0]       req_rate_y,
   input  logic signed [cfa_pkg::AW-1:0]       req_rate_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cfa_pkg::AW-1:0]       rsp_fused_x,
   output logic signed [cfa_pkg::AW-1:0]       rsp_fused_y,
   output logic signed [cfa_pkg::AW-1:0]       rsp_fused_z,
   input  logic                                csr_write,
   input  logic [cfa_pkg::IDXW-1:0]            csr_index,
   input  logic [cfa_pkg::CSRW-1:0]            csr_wdata
);
   import cfa_pkg::*;

   cfg_type              cfg;
   cmd_type              cmd;
   logic signed [AW-1:0] angle_vec [AXES];
   logic signed [AW-1:0] rate_vec  [AXES];
   logic signed [AW-1:0] fused_vec [AXES];

   // axis packing
   assign angle_vec[0] = req_angle_x;
   assign angle_vec[1] = req_angle_y;
   assign angle_vec[2] = req_angle_z;
   assign rate_vec[0]  = req_rate_x;
   assign rate_vec[1]  = req_rate_y;
   assign rate_vec[2]  = req_rate_z;

   assign rsp_fused_x = fused_vec[0];
   assign rsp_fused_y = fused_vec[1];
   assign rsp_fused_z = fused_vec[2];

   cfa_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .angle_in  (angle_vec),
      .rate_in   (rate_vec),
      .fused_out (fused_vec)
   );

endmodule
